// ===== design/btpc_pkg.sv =====
// shared types and constants of the barometric temperature and pressure compensation block
package btpc_pkg;

    localparam int ADC_W = 20;   // raw converter reading width
    localparam int MULB_W = 17;  // signed coefficient operand of the 64x16 multiplier
    localparam int DIV_STEPS = 64;  // one quotient bit per divider stage

    // configuration register indexes
    localparam logic [7:0] CFG_IDX_TEMP_CAL = 8'd0;
    localparam logic [7:0] CFG_IDX_PRESS_LO = 8'd1;
    localparam logic [7:0] CFG_IDX_PRESS_HI = 8'd2;
    localparam logic [7:0] CFG_IDX_P9 = 8'd3;

    // arithmetic constants
    localparam int C_T_OFFSET = 128000;
    localparam int C_PRESS_BASE = 1048576;
    localparam int C_PRESS_SCALE = 3125;
    localparam int C_T_ROUND = 128;
    localparam int C_SH_BIAS = 47;
    localparam int C_SH_DEN = 33;
    localparam int C_SH_P4 = 35;
    localparam int C_SH_P5 = 17;
    localparam int C_SH_P2 = 12;
    localparam int C_SH_P3 = 8;
    localparam int C_SH_NUM = 31;
    localparam int C_SH_H = 13;
    localparam int C_SH_X1 = 25;
    localparam int C_SH_X2 = 19;
    localparam int C_SH_PF = 8;
    localparam int C_SH_P7 = 4;
    localparam int C_SH_V1 = 11;
    localparam int C_SH_V2 = 14;
    localparam int C_SH_TC = 8;

    // temperature results riding along the pressure path
    typedef struct packed {
        logic [31:0] tc;
        logic [31:0] tf;
        logic        dz;
    } t_side;

    // one finished result
    typedef struct packed {
        logic [31:0] press;
        logic [31:0] tf;
        logic [31:0] tc;
        logic        dz;
    } t_result;

endpackage

// ===== design/btpc_temp.sv =====
// five-stage temperature compensation pipeline, 32-bit wrapping arithmetic
module btpc_temp
    import btpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [ADC_W-1:0] i_adc_temp,
    input  logic [ADC_W-1:0] i_adc_press,
    input  logic [47:0]      i_temp_cal,
    output logic             o_vld,
    output logic [31:0]      o_tc,
    output logic [31:0]      o_tf,
    output logic [ADC_W-1:0] o_adc_press
);

    logic [4:0]       r_vld;
    logic [ADC_W-1:0] r_ap [0:4];

    logic signed [17:0] r1_a;
    logic signed [16:0] r1_b;
    logic signed [31:0] r2_m1;
    logic        [31:0] r2_bb;
    logic signed [31:0] r3_v1;
    logic        [31:0] r3_m2;
    logic        [31:0] r4_tf;
    logic        [31:0] r5_tc;
    logic        [31:0] r5_tf;

    logic signed [15:0] w_t2;
    logic signed [15:0] w_t3;
    logic signed [33:0] w_m1;
    logic signed [33:0] w_bb;
    logic signed [19:0] w_bbs;
    logic signed [35:0] w_m2;
    logic signed [31:0] w_v1;
    logic signed [31:0] w_v2;
    logic        [31:0] w_tc_pre;
    logic signed [31:0] w_tc;

    assign w_t2 = i_temp_cal[31:16];
    assign w_t3 = i_temp_cal[47:32];
    assign w_m1 = r1_a * w_t2;
    assign w_bb = r1_b * r1_b;
    assign w_bbs = r2_bb[31:12];
    assign w_m2 = w_bbs * w_t3;
    assign w_v1 = r2_m1 >>> C_SH_V1;
    assign w_v2 = $signed(r3_m2) >>> C_SH_V2;
    assign w_tc_pre = (r4_tf << 2) + r4_tf + 32'(C_T_ROUND);
    assign w_tc = $signed(w_tc_pre) >>> C_SH_TC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ap[0] <= i_adc_press;
            for (int i = 1; i < 5; i++) begin
                r_ap[i] <= r_ap[i-1];
            end
            r1_a  <= $signed({1'b0, i_adc_temp[19:3]}) - $signed({1'b0, i_temp_cal[15:0], 1'b0});
            r1_b  <= $signed({1'b0, i_adc_temp[19:4]}) - $signed({1'b0, i_temp_cal[15:0]});
            r2_m1 <= w_m1[31:0];
            r2_bb <= w_bb[31:0];
            r3_v1 <= w_v1;
            r3_m2 <= w_m2[31:0];
            r4_tf <= r3_v1 + w_v2;
            r5_tf <= r4_tf;
            r5_tc <= w_tc;
        end
    end

    assign o_vld = r_vld[4];
    assign o_tc = r5_tc;
    assign o_tf = r5_tf;
    assign o_adc_press = r_ap[4];

endmodule

// ===== design/btpc_mul64x16.sv =====
// two-stage low-64-bit product of a 64-bit word and a signed 17-bit coefficient
module btpc_mul64x16
    import btpc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [63:0]              i_a,
    input  logic signed [MULB_W-1:0] i_b,
    output logic [63:0]              o_p
);

    logic signed [MULB_W+32:0] w_lo;
    logic signed [MULB_W+31:0] w_hi;
    logic signed [MULB_W+32:0] r_lo;
    logic        [31:0]        r_hi;
    logic        [63:0]        r_p;

    // low half as unsigned, high half only matters modulo 2^32
    assign w_lo = $signed({1'b0, i_a[31:0]}) * i_b;
    assign w_hi = $signed(i_a[63:32]) * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= w_lo;
            r_hi <= w_hi[31:0];
            r_p  <= 64'(r_lo) + {r_hi, 32'b0};
        end
    end

    assign o_p = r_p;

endmodule

// ===== design/btpc_div.sv =====
// pipelined signed 64-bit divider, truncating, one quotient bit per stage
module btpc_div
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    input  t_side       i_side,
    output logic        o_vld,
    output logic [63:0] o_quo,
    output t_side       o_side
);

    logic [63:0] r_rem  [0:DIV_STEPS];
    logic [63:0] r_nq   [0:DIV_STEPS];
    logic [63:0] r_dvs  [0:DIV_STEPS];
    logic        r_neg  [0:DIV_STEPS];
    t_side       r_side [0:DIV_STEPS];
    logic        r_vld  [0:DIV_STEPS];

    logic        r_out_vld;
    logic [63:0] r_out_quo;
    t_side       r_out_side;

    // entry: take magnitudes, remember the quotient sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_nq[0]   <= i_num[63] ? 64'd0 - i_num : i_num;
            r_dvs[0]  <= i_den[63] ? 64'd0 - i_den : i_den;
            r_neg[0]  <= i_num[63] ^ i_den[63];
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [64:0] w_t;
        logic [64:0] w_sub;
        logic        w_ge;

        assign w_t = {r_rem[g], r_nq[g][63]};
        assign w_sub = w_t - {1'b0, r_dvs[g]};
        assign w_ge = w_t >= {1'b0, r_dvs[g]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= w_ge ? w_sub[63:0] : w_t[63:0];
                r_nq[g+1]   <= {r_nq[g][62:0], w_ge};
                r_dvs[g+1]  <= r_dvs[g];
                r_neg[g+1]  <= r_neg[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    // exit: restore the sign; most negative over minus one wraps by itself
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_quo  <= r_neg[DIV_STEPS] ? 64'd0 - r_nq[DIV_STEPS] : r_nq[DIV_STEPS];
            r_out_side <= r_side[DIV_STEPS];
        end
    end

    assign o_vld = r_out_vld;
    assign o_quo = r_out_quo;
    assign o_side = r_out_side;

endmodule

// ===== design/baro_temp_pressure_compensate.sv =====
// top level of the barometric temperature and pressure compensation pipeline
//
//  channel   direction  handshake                  payload
//  s         in         i_s_tvalid / o_s_tready    i_s_tdata: adc_temp, adc_press
//  m         out        o_m_tvalid / i_m_tready    o_m_tdata: temp_centideg, fine_temp,
//                                                  press_q24_8; o_m_tuser: div_zero
//  cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one reading pair per cycle while the skid register is empty; depth comes mostly from
// the 64-stage quotient pipeline of the divider plus the stages before and after it
// i_rst_n is synchronous, active low; it clears valid bits and the calibration registers
// a result not taken moves into an output skid register; while that is full the whole
// pipeline holds, so o_s_tready is the skid being empty; o_cfg_ready is always high,
// and the user must write calibration while no transaction is in flight; not enforced
module baro_temp_pressure_compensate
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [19:0] adc_temp, [39:20] adc_press
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // [31:0] temp_centideg, [63:32] fine_temp,
                                     // [95:64] press_q24_8
    output logic [0:0]  o_m_tuser,   // [0] div_zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // calibration registers
    logic [47:0] r_temp_cal;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [15:0] r_p9;

    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_p2 = r_press_lo[31:16];
    assign w_p3 = r_press_lo[47:32];
    assign w_p4 = r_press_lo[63:48];
    assign w_p5 = r_press_hi[15:0];
    assign w_p6 = r_press_hi[31:16];
    assign w_p7 = r_press_hi[47:32];
    assign w_p8 = r_press_hi[63:48];
    assign w_p9 = r_p9;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal <= '0;
            r_press_lo <= '0;
            r_press_hi <= '0;
            r_p9       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX_TEMP_CAL: r_temp_cal <= i_cfg_data[47:0];
                CFG_IDX_PRESS_LO: r_press_lo <= i_cfg_data;
                CFG_IDX_PRESS_HI: r_press_hi <= i_cfg_data;
                CFG_IDX_P9:       r_p9 <= i_cfg_data[15:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // global advance: everything moves unless the skid register holds a result
    logic    r_skid_vld;
    t_result r_skid;
    logic    w_en;

    assign w_en = !r_skid_vld;
    assign o_s_tready = w_en;

    // temperature front end
    logic             t_vld;
    logic [31:0]      t_tc;
    logic [31:0]      t_tf;
    logic [ADC_W-1:0] t_ap;

    btpc_temp u_temp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (i_s_tvalid),
        .i_adc_temp  (i_s_tdata[19:0]),
        .i_adc_press (i_s_tdata[39:20]),
        .i_temp_cal  (r_temp_cal),
        .o_vld       (t_vld),
        .o_tc        (t_tc),
        .o_tf        (t_tf),
        .o_adc_press (t_ap)
    );

    // p1: var1 = fine temperature - offset, exact in 33 bits
    logic               r1_vld;
    t_side              r1_side;
    logic [ADC_W-1:0]   r1_ap;
    logic signed [32:0] r1_w1;

    // p2: square and the two linear terms
    logic               r2_vld;
    t_side              r2_side;
    logic [ADC_W-1:0]   r2_ap;
    logic [63:0]        r2_sq;
    logic signed [48:0] r2_w1p5;
    logic signed [48:0] r2_w1p2;

    logic signed [65:0] w_sq;
    logic signed [48:0] w_w1p5;
    logic signed [48:0] w_w1p2;

    assign w_sq = r1_w1 * r1_w1;
    assign w_w1p5 = r1_w1 * w_p5;
    assign w_w1p2 = r1_w1 * w_p2;

    // p3..p4: square times p6 and p3
    logic        r34_vld  [0:1];
    t_side       r34_side [0:1];
    logic [ADC_W-1:0] r34_ap [0:1];
    logic [48:0] r34_w1p5 [0:1];
    logic [48:0] r34_w1p2 [0:1];
    logic [63:0] m_p6;
    logic [63:0] m_p3;

    btpc_mul64x16 u_mul_p6 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r2_sq),
        .i_b   ({w_p6[15], w_p6}),
        .o_p   (m_p6)
    );

    btpc_mul64x16 u_mul_p3 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r2_sq),
        .i_b   ({w_p3[15], w_p3}),
        .o_p   (m_p3)
    );

    // p5: var2 complete, var1 before the p1 scale
    logic             r5_vld;
    t_side            r5_side;
    logic [ADC_W-1:0] r5_ap;
    logic [63:0]      r5_w2;
    logic [63:0]      r5_w1b;

    logic [63:0] w_w1p5_x;
    logic [63:0] w_w1p2_x;
    logic [63:0] w_p4_x;
    logic [63:0] w_m3_s;

    assign w_w1p5_x = {{15{r34_w1p5[1][48]}}, r34_w1p5[1]};
    assign w_w1p2_x = {{15{r34_w1p2[1][48]}}, r34_w1p2[1]};
    assign w_p4_x = {{48{w_p4[15]}}, w_p4};
    assign w_m3_s = $signed(m_p3) >>> C_SH_P3;

    // p6..p7: times p1
    logic             r67_vld  [0:1];
    t_side            r67_side [0:1];
    logic [ADC_W-1:0] r67_ap   [0:1];
    logic [63:0]      r67_w2   [0:1];
    logic [63:0]      m_p1;

    btpc_mul64x16 u_mul_p1 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r5_w1b),
        .i_b   ({1'b0, r_press_lo[15:0]}),
        .o_p   (m_p1)
    );

    // p8: divisor, zero check, numerator before the scale
    logic        r8_vld;
    t_side       r8_side;
    logic [63:0] r8_den;
    logic [63:0] r8_x;

    logic [63:0] w_den;
    logic [20:0] w_pb;

    assign w_den = $signed(m_p1) >>> C_SH_DEN;
    assign w_pb = 21'(C_PRESS_BASE) - {1'b0, r67_ap[1]};

    // p9..p10: numerator times the scale constant
    logic        r910_vld  [0:1];
    t_side       r910_side [0:1];
    logic [63:0] r910_den  [0:1];
    logic [63:0] m_num;

    btpc_mul64x16 u_mul_scale (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r8_x),
        .i_b   (MULB_W'(C_PRESS_SCALE)),
        .o_p   (m_num)
    );

    // division
    logic        d_vld;
    logic [63:0] d_quo;
    t_side       d_side;

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r910_vld[1]),
        .i_num   (m_num),
        .i_den   (r910_den[1]),
        .i_side  (r910_side[1]),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    // q1..q2: h*h modulo 2^64 from 32-bit partial products
    logic        rq1_vld;
    t_side       rq1_side;
    logic [63:0] rq1_q;
    logic [63:0] rq1_ll;
    logic [30:0] rq1_cr;

    logic        rq2_vld;
    t_side       rq2_side;
    logic [63:0] rq2_q;
    logic [63:0] rq2_hh;

    logic [63:0] w_h;
    logic [63:0] w_ll;
    logic [63:0] w_cr;

    assign w_h = $signed(d_quo) >>> C_SH_H;
    assign w_ll = w_h[31:0] * w_h[31:0];
    assign w_cr = w_h[31:0] * w_h[63:32];

    // q3..q4: p9 and p8 correction terms
    logic        rq34_vld  [0:1];
    t_side       rq34_side [0:1];
    logic [63:0] rq34_q    [0:1];
    logic [63:0] m_x1;
    logic [63:0] m_x2;

    btpc_mul64x16 u_mul_p9 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (rq2_hh),
        .i_b   ({w_p9[15], w_p9}),
        .o_p   (m_x1)
    );

    btpc_mul64x16 u_mul_p8 (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (rq2_q),
        .i_b   ({w_p8[15], w_p8}),
        .o_p   (m_x2)
    );

    // q5: sum of quotient and corrections
    logic        rq5_vld;
    t_side       rq5_side;
    logic [63:0] rq5_sum;

    logic [63:0] w_x1_s;
    logic [63:0] w_x2_s;
    logic [63:0] w_sum_s;
    logic [31:0] w_p7_x;

    assign w_x1_s = $signed(m_x1) >>> C_SH_X1;
    assign w_x2_s = $signed(m_x2) >>> C_SH_X2;
    assign w_sum_s = $signed(rq5_sum) >>> C_SH_PF;
    assign w_p7_x = {{12{w_p7[15]}}, w_p7, 4'b0};

    // q6: output register
    logic    r_q6_vld;
    t_result r_q6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r34_vld[0]  <= 1'b0;
            r34_vld[1]  <= 1'b0;
            r5_vld      <= 1'b0;
            r67_vld[0]  <= 1'b0;
            r67_vld[1]  <= 1'b0;
            r8_vld      <= 1'b0;
            r910_vld[0] <= 1'b0;
            r910_vld[1] <= 1'b0;
            rq1_vld     <= 1'b0;
            rq2_vld     <= 1'b0;
            rq34_vld[0] <= 1'b0;
            rq34_vld[1] <= 1'b0;
            rq5_vld     <= 1'b0;
            r_q6_vld    <= 1'b0;
        end else if (w_en) begin
            r1_vld      <= t_vld;
            r2_vld      <= r1_vld;
            r34_vld[0]  <= r2_vld;
            r34_vld[1]  <= r34_vld[0];
            r5_vld      <= r34_vld[1];
            r67_vld[0]  <= r5_vld;
            r67_vld[1]  <= r67_vld[0];
            r8_vld      <= r67_vld[1];
            r910_vld[0] <= r8_vld;
            r910_vld[1] <= r910_vld[0];
            rq1_vld     <= d_vld;
            rq2_vld     <= rq1_vld;
            rq34_vld[0] <= rq2_vld;
            rq34_vld[1] <= rq34_vld[0];
            rq5_vld     <= rq34_vld[1];
            r_q6_vld    <= rq5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // p1
            r1_side <= '{tc: t_tc, tf: t_tf, dz: 1'b0};
            r1_ap   <= t_ap;
            r1_w1   <= $signed({t_tf[31], t_tf}) - 33'sd128000;
            // p2
            r2_side <= r1_side;
            r2_ap   <= r1_ap;
            r2_sq   <= w_sq[63:0];
            r2_w1p5 <= w_w1p5;
            r2_w1p2 <= w_w1p2;
            // p3..p4
            r34_side[0] <= r2_side;
            r34_side[1] <= r34_side[0];
            r34_ap[0]   <= r2_ap;
            r34_ap[1]   <= r34_ap[0];
            r34_w1p5[0] <= r2_w1p5;
            r34_w1p5[1] <= r34_w1p5[0];
            r34_w1p2[0] <= r2_w1p2;
            r34_w1p2[1] <= r34_w1p2[0];
            // p5
            r5_side <= r34_side[1];
            r5_ap   <= r34_ap[1];
            r5_w2   <= m_p6 + (w_w1p5_x << C_SH_P5) + (w_p4_x << C_SH_P4);
            r5_w1b  <= w_m3_s + (w_w1p2_x << C_SH_P2) + (64'd1 << C_SH_BIAS);
            // p6..p7
            r67_side[0] <= r5_side;
            r67_side[1] <= r67_side[0];
            r67_ap[0]   <= r5_ap;
            r67_ap[1]   <= r67_ap[0];
            r67_w2[0]   <= r5_w2;
            r67_w2[1]   <= r67_w2[0];
            // p8: zero divisor marks the item
            r8_side    <= '{tc: r67_side[1].tc, tf: r67_side[1].tf,
                            dz: (w_den == 64'd0)};
            r8_den     <= w_den;
            r8_x       <= (64'(w_pb) << C_SH_NUM) - r67_w2[1];
            // p9..p10
            r910_side[0] <= r8_side;
            r910_side[1] <= r910_side[0];
            r910_den[0]  <= r8_den;
            r910_den[1]  <= r910_den[0];
            // q1
            rq1_side <= d_side;
            rq1_q    <= d_quo;
            rq1_ll   <= w_ll;
            rq1_cr   <= w_cr[30:0];
            // q2: cross term counts twice, hence the shift by 33
            rq2_side <= rq1_side;
            rq2_q    <= rq1_q;
            rq2_hh   <= rq1_ll + {rq1_cr, 33'b0};
            // q3..q4
            rq34_side[0] <= rq2_side;
            rq34_side[1] <= rq34_side[0];
            rq34_q[0]    <= rq2_q;
            rq34_q[1]    <= rq34_q[0];
            // q5
            rq5_side <= rq34_side[1];
            rq5_sum  <= rq34_q[1] + w_x1_s + w_x2_s;
            // q6
            r_q6.tc    <= rq5_side.tc;
            r_q6.tf    <= rq5_side.tf;
            r_q6.dz    <= rq5_side.dz;
            r_q6.press <= rq5_side.dz ? 32'd0 : w_sum_s[31:0] + w_p7_x;
        end
    end

    // output skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_m_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_q6_vld && !i_m_tready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld && r_q6_vld && !i_m_tready) begin
            r_skid <= r_q6;
        end
    end

    t_result w_out;

    assign w_out = r_skid_vld ? r_skid : r_q6;
    assign o_m_tvalid = r_skid_vld || r_q6_vld;
    assign o_m_tdata = {w_out.press, w_out.tf, w_out.tc};
    assign o_m_tuser = w_out.dz;

    // a zero divisor always delivers zero pressure
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[95:64] == 32'd0))
        else $error("zero divisor result with nonzero pressure");

    // a held result in the skid register stays until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_m_tready) |=> (r_skid_vld && $stable(r_skid)))
        else $error("skid register lost or changed a pending result");

    // while the pipeline holds, the last stage keeps its item
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_q6_vld) && $stable(r_q6)))
        else $error("last stage moved during a stall");

endmodule

// ===== verif/btpc_checker.sv =====
// checker for the compensation block: predicts each result and compares it
`timescale 1ns / 100ps
module btpc_checker
    import btpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    logic [47:0] temp_cal;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] p9_reg;

    t_result readings_due[$];

    function automatic t_result compensate(logic [19:0] adc_t, logic [19:0] adc_p);
        logic signed [31:0] t1, t2, t3, a, b, v1, v2, tf, tc;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] w1, w2, num, p, h, x1, x2;
        logic [63:0] mn, md, q;
        t_result r;
        t1 = {16'd0, temp_cal[15:0]};
        t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
        t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
        a = {15'd0, adc_t[19:3]} - (t1 <<< 1);
        v1 = (a * t2) >>> 11;
        b = {16'd0, adc_t[19:4]} - t1;
        v2 = (((b * b) >>> 12) * t3) >>> 14;
        tf = v1 + v2;
        tc = (tf * 5 + 128) >>> 8;
        p1 = {48'd0, press_lo[15:0]};
        p2 = {{48{press_lo[31]}}, press_lo[31:16]};
        p3 = {{48{press_lo[47]}}, press_lo[47:32]};
        p4 = {{48{press_lo[63]}}, press_lo[63:48]};
        p5 = {{48{press_hi[15]}}, press_hi[15:0]};
        p6 = {{48{press_hi[31]}}, press_hi[31:16]};
        p7 = {{48{press_hi[47]}}, press_hi[47:32]};
        p8 = {{48{press_hi[63]}}, press_hi[63:48]};
        p9 = {{48{p9_reg[15]}}, p9_reg};
        w1 = {{32{tf[31]}}, tf} - 64'sd128000;
        w2 = w1 * w1 * p6;
        w2 = w2 + ((w1 * p5) <<< 17);
        w2 = w2 + (p4 <<< 35);
        w1 = ((w1 * w1 * p3) >>> 8) + ((w1 * p2) <<< 12);
        w1 = (((64'sd1 <<< 47) + w1) * p1) >>> 33;
        r.tc = tc;
        r.tf = tf;
        r.dz = (w1 == 0);
        r.press = '0;
        if (w1 != 0) begin
            num = ((64'sd1048576 - {44'd0, adc_p}) <<< 31) - w2;
            num = num * 64'sd3125;
            // truncating division on magnitudes; most negative by -1 wraps
            mn = num[63] ? -num : num;
            md = w1[63] ? -w1 : w1;
            q = mn / md;
            p = (num[63] != w1[63]) ? -q : q;
            h = p >>> 13;
            x1 = (p9 * h * h) >>> 25;
            x2 = (p8 * p) >>> 19;
            p = ((p + x1 + x2) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
        end
        return r;
    endfunction

    assign o_pending = readings_due.size();

    always @(posedge i_clk) begin
        t_result want, got;
        int bad;
        bad = 0;
        if (!i_rst_n) begin
            temp_cal <= '0;
            press_lo <= '0;
            press_hi <= '0;
            p9_reg <= '0;
            o_errors <= 0;
            readings_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDX_TEMP_CAL: temp_cal <= i_cfg_data[47:0];
                    CFG_IDX_PRESS_LO: press_lo <= i_cfg_data;
                    CFG_IDX_PRESS_HI: press_hi <= i_cfg_data;
                    CFG_IDX_P9:       p9_reg <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                readings_due.push_back(compensate(i_s_tdata[19:0], i_s_tdata[39:20]));
            if (i_m_tvalid && i_m_tready) begin
                got.tc = i_m_tdata[31:0];
                got.tf = i_m_tdata[63:32];
                got.press = i_m_tdata[95:64];
                got.dz = i_m_tuser[0];
                if (readings_due.size() == 0) begin
                    $error("result transaction with nothing expected");
                    bad = bad + 1;
                end else begin
                    want = readings_due.pop_front();
                    if (got.tc !== want.tc) begin
                        $error("temp_centideg expected %h got %h", want.tc, got.tc);
                        bad = bad + 1;
                    end
                    if (got.tf !== want.tf) begin
                        $error("fine_temp expected %h got %h", want.tf, got.tf);
                        bad = bad + 1;
                    end
                    if (got.press !== want.press) begin
                        $error("press_q24_8 expected %h got %h", want.press, got.press);
                        bad = bad + 1;
                    end
                    if (got.dz !== want.dz) begin
                        $error("div_zero expected %b got %b", want.dz, got.dz);
                        bad = bad + 1;
                    end
                end
            end
            o_errors <= o_errors + bad;
        end
    end

endmodule

// ===== verif/baro_temp_pressure_compensate_tb.sv =====
// testbench top: stimulus, calibration phases and verdict for the compensation block
`timescale 1ns / 100ps
module baro_temp_pressure_compensate_tb;
    import btpc_pkg::*;

    localparam int LATENCY = 87;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [95:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    int  errors;
    int  pending;
    int  cycles = 0;
    bit  calm = 1'b0;     // no idling on either side in the last part

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    baro_temp_pressure_compensate i_dut (.*);

    btpc_checker i_chk (
        .i_clk, .i_rst_n,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stalls in random bursts
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            i_m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 11);
                i_m_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end
        end
    end

    // one register write transaction
    task automatic write_reg(logic [7:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // one reading pair transaction, with an occasional gap ahead of it
    task automatic send_pair(logic [19:0] adc_t, logic [19:0] adc_p);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {adc_p, adc_t};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // calibration near the usual sensor trim so pressure paths are exercised
    task automatic load_typical();
        logic [15:0] t1, p1;
        t1 = 16'($urandom_range(20000, 32000));
        p1 = 16'($urandom_range(30000, 40000));
        write_reg(CFG_IDX_TEMP_CAL, {$urandom, 16'($urandom_range(24000, 28000)), t1});
        write_reg(CFG_IDX_PRESS_LO, {16'($urandom_range(2000, 9000)),
                                     16'($urandom_range(4000, 6000)),
                                     -16'($urandom_range(9000, 12000)), p1});
        write_reg(CFG_IDX_PRESS_HI, {-16'($urandom_range(12000, 16000)),
                                     16'($urandom_range(9000, 16000)),
                                     -16'($urandom_range(1, 10)),
                                     16'($urandom_range(100, 300))});
        write_reg(CFG_IDX_P9, 64'($urandom_range(4000, 7000)));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration: all-zero gives a zero divisor
        send_pair('0, '0);
        send_pair('1, '1);
        drain();

        // typical trim, directed extremes of both readings
        load_typical();
        write_reg(8'hff, '1);     // out-of-range index, ignored
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair('0, '1);
        send_pair('1, '0);
        send_pair(20'h80000, 20'h80000);
        send_pair(20'd519888, 20'd415148);
        send_pair(20'h55555, 20'haaaaa);
        send_pair(20'haaaaa, 20'h55555);
        drain();

        // all-ones calibration extremes
        write_reg(CFG_IDX_TEMP_CAL, '1);
        write_reg(CFG_IDX_PRESS_LO, '1);
        write_reg(CFG_IDX_PRESS_HI, '1);
        write_reg(CFG_IDX_P9, '1);
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair(20'h80000, 20'h7ffff);
        drain();

        // most negative signed coefficients, largest p1
        write_reg(CFG_IDX_TEMP_CAL, 48'h8000_8000_ffff);
        write_reg(CFG_IDX_PRESS_LO, 64'h8000_8000_8000_ffff);
        write_reg(CFG_IDX_PRESS_HI, 64'h8000_8000_8000_8000);
        write_reg(CFG_IDX_P9, 64'h8000);
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair(20'h12345, 20'h6789a);
        drain();

        // random phases: mostly typical trim, some fully random trim
        for (int ph = 0; ph < 10; ph++) begin
            if (ph == 9) calm = 1'b1;
            if (ph % 3 == 2) begin
                write_reg(CFG_IDX_TEMP_CAL, {$urandom, $urandom});
                write_reg(CFG_IDX_PRESS_LO, {$urandom, $urandom});
                write_reg(CFG_IDX_PRESS_HI, {$urandom, $urandom});
                write_reg(CFG_IDX_P9, {$urandom, $urandom});
            end else begin
                load_typical();
            end
            repeat (100) send_pair(20'($urandom), 20'($urandom));
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
